// ===== sv/mdio_management_master_defines.svh =====
`ifndef MDIO_MANAGEMENT_MASTER_DEFINES_SVH
`define MDIO_MANAGEMENT_MASTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdio master check failed");

// next-cycle implication, checked outside reset
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdio master check failed");

`endif

// ===== sv/mdio_mm_pkg.sv =====
package mdio_mm_pkg;

    localparam int PREAMBLE_BITS = 32;
    localparam int FRAME_BITS    = 32;
    localparam int TOTAL_BITS    = PREAMBLE_BITS + FRAME_BITS;
    localparam int POS_W         = 7;
    localparam int DIV_W         = 16;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 16;

    // frame bit numbers counted from the end of the preamble
    localparam int Q_DRIVE_END   = 14;
    localparam int Q_ACK_BIT     = 15;
    localparam int Q_DATA_FIRST  = 16;
    localparam int Q_DATA_END    = 32;

    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 24;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_DIVISOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE        = 2'd1;

    localparam logic [DIV_W-1:0] DIVISOR_RESET = 16'd255;

    localparam logic [1:0] FRAME_START = 2'b01;
    localparam logic [1:0] OP_READ     = 2'b10;
    localparam logic [1:0] OP_WRITE    = 2'b01;
    localparam logic [1:0] TA_WRITE    = 2'b10;

    typedef struct packed {
        logic              mode;
        logic              access_write;
        logic [ADDR_W-1:0] phy_address;
        logic [ADDR_W-1:0] register_address;
        logic [DATA_W-1:0] write_value;
        logic              mdio_in;
    } t_item;

    typedef struct packed {
        logic              mdc;
        logic              mdio_out;
        logic              mdio_drive;
        logic              busy_res;
        logic              acked;
        logic [DATA_W-1:0] read_value;
        logic              start_rejected;
    } t_result;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

endpackage

// ===== sv/mdio_mm_core.sv =====
`include "mdio_management_master_defines.svh"

module mdio_mm_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mdio_mm_pkg::t_cfg_write i_cfg,
    input  logic                 i_step,
    input  mdio_mm_pkg::t_item   i_item,
    output mdio_mm_pkg::t_result o_result
);

    logic [mdio_mm_pkg::DIV_W-1:0]      r_div, n_div;
    logic                               r_enable, n_enable;
    logic [mdio_mm_pkg::DIV_W-1:0]      r_count, n_count;
    logic [mdio_mm_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [mdio_mm_pkg::FRAME_BITS-1:0] r_shift, n_shift;
    logic [mdio_mm_pkg::DATA_W-1:0]     r_capture, n_capture;
    logic                               r_is_write, n_is_write;
    logic                               r_busy, n_busy;
    logic                               r_ack, n_ack;

    logic [mdio_mm_pkg::DIV_W-1:0] eff_div;
    logic [mdio_mm_pkg::DIV_W-1:0] half;
    logic [mdio_mm_pkg::POS_W-1:0] q_cur;
    logic [mdio_mm_pkg::POS_W-1:0] q_next;
    logic [mdio_mm_pkg::POS_W-1:0] pos_inc;
    logic                          rejected;

    assign eff_div = (r_div == '0) ? mdio_mm_pkg::DIV_W'(1) : r_div;
    assign half    = mdio_mm_pkg::DIV_W'(({1'b0, eff_div} + 17'd1) >> 1);
    assign q_cur   = r_pos - mdio_mm_pkg::POS_W'(mdio_mm_pkg::PREAMBLE_BITS);
    assign pos_inc = r_pos + mdio_mm_pkg::POS_W'(1);

    always_comb begin
        n_div      = r_div;
        n_enable   = r_enable;
        n_count    = r_count;
        n_pos      = r_pos;
        n_shift    = r_shift;
        n_capture  = r_capture;
        n_is_write = r_is_write;
        n_busy     = r_busy;
        n_ack      = r_ack;
        rejected   = 1'b0;

        if (i_step) begin
            if (i_item.mode) begin
                if (r_busy || !r_enable) begin
                    rejected = 1'b1;
                end else begin
                    n_is_write = i_item.access_write;
                    n_shift    = {mdio_mm_pkg::FRAME_START,
                                  i_item.access_write ? mdio_mm_pkg::OP_WRITE
                                                      : mdio_mm_pkg::OP_READ,
                                  i_item.phy_address, i_item.register_address,
                                  i_item.access_write ? {mdio_mm_pkg::TA_WRITE,
                                                         i_item.write_value}
                                                      : 18'd0};
                    n_busy     = 1'b1;
                    n_count    = '0;
                    n_pos      = '0;
                end
            end else if (r_busy && r_enable) begin
                // sample at the rising mdc edge
                if (r_count == half && !r_is_write &&
                    r_pos >= mdio_mm_pkg::POS_W'(mdio_mm_pkg::PREAMBLE_BITS)) begin
                    if (q_cur == mdio_mm_pkg::POS_W'(mdio_mm_pkg::Q_ACK_BIT)) begin
                        n_ack = !i_item.mdio_in;
                    end else if (q_cur >= mdio_mm_pkg::POS_W'(mdio_mm_pkg::Q_DATA_FIRST) &&
                                 q_cur < mdio_mm_pkg::POS_W'(mdio_mm_pkg::Q_DATA_END)) begin
                        n_capture = {r_capture[mdio_mm_pkg::DATA_W-2:0], i_item.mdio_in};
                    end
                end
                // end of mdc period
                if (r_count >= eff_div) begin
                    n_count = '0;
                    if (r_pos >= mdio_mm_pkg::POS_W'(mdio_mm_pkg::PREAMBLE_BITS)) begin
                        n_shift = {r_shift[mdio_mm_pkg::FRAME_BITS-2:0], 1'b0};
                    end
                    n_pos = pos_inc;
                    if (pos_inc >= mdio_mm_pkg::POS_W'(mdio_mm_pkg::TOTAL_BITS)) begin
                        n_busy = 1'b0;
                        n_pos  = '0;
                    end
                end else begin
                    n_count = r_count + mdio_mm_pkg::DIV_W'(1);
                end
            end
        end

        if (i_cfg.valid) begin
            case (i_cfg.index)
                mdio_mm_pkg::REG_CLOCK_DIVISOR: begin
                    n_div = i_cfg.data;
                end
                mdio_mm_pkg::REG_ENABLE: begin
                    n_enable = i_cfg.data[0];
                    if (!i_cfg.data[0]) begin
                        n_busy  = 1'b0;
                        n_count = '0;
                        n_pos   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // pin levels after this item
    assign q_next = n_pos - mdio_mm_pkg::POS_W'(mdio_mm_pkg::PREAMBLE_BITS);

    always_comb begin
        o_result                = '0;
        o_result.busy_res       = n_busy;
        o_result.acked          = n_ack;
        o_result.read_value     = n_capture;
        o_result.start_rejected = rejected;
        if (n_busy) begin
            o_result.mdc = (n_count >= half);
            if (n_pos < mdio_mm_pkg::POS_W'(mdio_mm_pkg::PREAMBLE_BITS)) begin
                o_result.mdio_drive = 1'b1;
                o_result.mdio_out   = 1'b1;
            end else if (q_next < mdio_mm_pkg::POS_W'(mdio_mm_pkg::Q_DRIVE_END) ||
                         n_is_write) begin
                o_result.mdio_drive = 1'b1;
                o_result.mdio_out   = n_shift[mdio_mm_pkg::FRAME_BITS-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div      <= mdio_mm_pkg::DIVISOR_RESET;
            r_enable   <= 1'b0;
            r_count    <= '0;
            r_pos      <= '0;
            r_shift    <= '0;
            r_capture  <= '0;
            r_is_write <= 1'b0;
            r_busy     <= 1'b0;
            r_ack      <= 1'b0;
        end else begin
            r_div      <= n_div;
            r_enable   <= n_enable;
            r_count    <= n_count;
            r_pos      <= n_pos;
            r_shift    <= n_shift;
            r_capture  <= n_capture;
            r_is_write <= n_is_write;
            r_busy     <= n_busy;
            r_ack      <= n_ack;
        end
    end

    `MM_ASSERT_NOW(a_busy_needs_enable, i_clk, i_rst_n, r_busy, r_enable)
    `MM_ASSERT_NOW(a_idle_counters_clear, i_clk, i_rst_n, !r_busy, (r_count == '0) && (r_pos == '0))
    `MM_ASSERT_NOW(a_pos_in_frame, i_clk, i_rst_n, r_busy, r_pos < mdio_mm_pkg::POS_W'(mdio_mm_pkg::TOTAL_BITS))
    `MM_ASSERT_NEXT(a_reject_keeps_state, i_clk, i_rst_n, i_step && rejected && !i_cfg.valid, $stable(r_busy) && $stable(r_shift))

endmodule

// ===== sv/mdio_management_master.sv =====
// channel  | direction | handshake                       | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready   | s_axis_tdata, s_axis_tuser (mode)
// m_axis   | out       | m_axis_tvalid / m_axis_tready   | m_axis_tdata
// cfg      | in        | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// one item per clock while m_axis is not stalled; items pass through the input register and the result register
// each tick or start is one pass through the frame logic between those registers
// a stall on m_axis holds the result and, once the input register is full, lowers s_axis_tready in the same cycle
// reset is synchronous, active low: pipeline empty, frame idle, divisor 255, disabled
// cfg is always ready; a write takes effect on the next clock
`include "mdio_management_master_defines.svh"

module mdio_management_master (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [0] access_write, [5:1] phy_address, [10:6] register_address,
    // [26:11] write_value, [27] mdio_in, [31:28] zero
    input  logic [mdio_mm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] mode
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [0] mdc, [1] mdio_out, [2] mdio_drive, [3] busy_res, [4] acked,
    // [20:5] read_value, [21] start_rejected, [23:22] zero
    output logic [mdio_mm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mdio_mm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mdio_mm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                    r_in_valid;
    mdio_mm_pkg::t_item      r_in_item;
    logic                    r_out_valid;
    mdio_mm_pkg::t_result    r_out;
    mdio_mm_pkg::t_result    result;
    mdio_mm_pkg::t_cfg_write cfg;
    logic                    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign cfg.valid = i_cfg_valid;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.mode             <= s_axis_tuser;
            r_in_item.access_write     <= s_axis_tdata[0];
            r_in_item.phy_address      <= s_axis_tdata[5:1];
            r_in_item.register_address <= s_axis_tdata[10:6];
            r_in_item.write_value      <= s_axis_tdata[26:11];
            r_in_item.mdio_in          <= s_axis_tdata[27];
        end
    end

    mdio_mm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.start_rejected, r_out.read_value, r_out.acked,
                            r_out.busy_res, r_out.mdio_drive, r_out.mdio_out, r_out.mdc};

    `MM_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)
    `MM_ASSERT_NEXT(a_stall_keeps_out, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out))
    `MM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, s_axis_tready)

endmodule
